[src/skot_pkg.sv]
package skot_pkg;

    // Default table size in entries.
    localparam int TABLE_DEPTH_DEF = 1024;

    // Fixed field widths.
    localparam int KEY_W      = 31;
    localparam int OFS_W      = 32;
    localparam int SLOT_OUT_W = 10;
    localparam int IPOS_W     = 18;
    localparam int CFG_W      = 8;
    localparam int CFG_IDX_W  = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_BYTES  = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] HEADER_BYTES_RST = 8'd1;
    localparam logic [CFG_W-1:0] ENTRY_BYTES_RST  = 8'd12;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_REDUCE = 2'd1,
        S_APPLY  = 2'd2
    } t_state;

    // Broadcast control from the sequencer to every cell of the chain.
    typedef struct packed {
        logic             cmp;
        logic             ins;
        logic             rem;
        logic [KEY_W-1:0] key;
        logic [OFS_W-1:0] ofs;
    } t_cell_ctl;

endpackage

[src/skot_req_if.sv]
interface skot_req_if import skot_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [1:0]       opcode;
    logic [KEY_W-1:0] key;
    logic [OFS_W-1:0] record_offset;

    modport source(output valid, output opcode, output key, output record_offset,
                   input ready);
    modport sink(input valid, input opcode, input key, input record_offset,
                 output ready);
endinterface

[src/skot_rsp_if.sv]
interface skot_rsp_if import skot_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [1:0]            status;
    logic [OFS_W-1:0]      found_offset;
    logic [SLOT_OUT_W-1:0] slot;
    logic [IPOS_W-1:0]     index_position;

    modport source(output valid, output status, output found_offset, output slot,
                   output index_position, input ready);
    modport sink(input valid, input status, input found_offset, input slot,
                 input index_position, output ready);
endinterface

[src/skot_cell.sv]
module skot_cell import skot_pkg::*; #(
    parameter int INDEX = 0,
    parameter int CNT_W = 11
) (
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  logic [CNT_W-1:0] i_count,
    input  logic             i_prev_lt,
    input  logic [KEY_W-1:0] i_prev_key,
    input  logic [OFS_W-1:0] i_prev_ofs,
    input  logic [KEY_W-1:0] i_next_key,
    input  logic [OFS_W-1:0] i_next_ofs,
    output logic [KEY_W-1:0] o_key,
    output logic [OFS_W-1:0] o_ofs,
    output logic             o_lt,
    output logic             o_eq
);

    logic [KEY_W-1:0] r_key, n_key;
    logic [OFS_W-1:0] r_ofs, n_ofs;
    logic             r_lt, n_lt;
    logic             r_eq, n_eq;
    logic             w_valid;
    logic             w_open;

    // Occupied when below the fill count; open to an insert up to the count.
    assign w_valid = CNT_W'(INDEX) <  i_count;
    assign w_open  = CNT_W'(INDEX) <= i_count;

    always_comb begin
        n_key = r_key;
        n_ofs = r_ofs;
        n_lt  = r_lt;
        n_eq  = r_eq;
        if (i_ctl.cmp) begin
            n_lt = w_valid && (r_key < i_ctl.key);
            n_eq = w_valid && (r_key == i_ctl.key);
        end
        if (i_ctl.ins && !r_lt && w_open) begin
            // Take the new pair at the boundary, else shift up from below.
            n_key = i_prev_lt ? i_ctl.key : i_prev_key;
            n_ofs = i_prev_lt ? i_ctl.ofs : i_prev_ofs;
        end else if (i_ctl.rem && !r_lt && w_valid) begin
            n_key = i_next_key;
            n_ofs = i_next_ofs;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_ofs <= n_ofs;
        r_lt  <= n_lt;
        r_eq  <= n_eq;
    end

    assign o_key = r_key;
    assign o_ofs = r_ofs;
    assign o_lt  = r_lt;
    assign o_eq  = r_eq;

endmodule

[src/skot_or_tree.sv]
module skot_or_tree import skot_pkg::*; #(
    parameter int N = 1024,
    parameter int W = 43
) (
    input  logic         i_clk,
    input  logic [W-1:0] i_leaf [N],
    output logic [W-1:0] o_root
);

    localparam int L = $clog2(N);
    localparam int P = 1 << L;

    // Heap order: node n merges nodes 2n and 2n+1; leaves sit at P..2P-1.
    logic [W-1:0] w_node [1:2*P-1];

    for (genvar g = 0; g < P; g++) begin : g_leaf
        if (g < N) begin : g_used
            assign w_node[P+g] = i_leaf[g];
        end else begin : g_pad
            assign w_node[P+g] = '0;
        end
    end

    for (genvar n = 1; n < P; n++) begin : g_node
        logic [W-1:0] r_sum;
        always_ff @(posedge i_clk) begin
            r_sum <= w_node[2*n] | w_node[2*n+1];
        end
        assign w_node[n] = r_sum;
    end

    assign o_root = w_node[1];

endmodule

[src/sorted_key_offset_table.sv]
// Channel   Dir  Payload                                        Handshake
// i_req     in   opcode, key, record_offset                     valid/ready
// o_rsp     out  status, found_offset, slot, index_position     valid/ready
// i_cfg_*   in   register index, write data                     write enable only
//
// A transaction runs from accept through the REDUCE and APPLY states back to IDLE, and no
// new request is accepted until then: every cell compares at the accept edge, the registered
// OR tree gathers the boundary cell while the sequencer waits in REDUCE, and the apply edge
// shifts the chain and loads the result register, which raises o_rsp.valid.
// Reset clears the fill count and loads header_bytes = 1, entry_bytes = 12; stored
// entries are not cleared. A stalled result register holds the apply step until it is free.
module sorted_key_offset_table import skot_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    skot_req_if.sink             i_req,
    skot_rsp_if.source           o_rsp,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W    = $clog2(TABLE_DEPTH);
    localparam int TREE_LAT = IDX_W;
    localparam int LAT_W    = $clog2(TREE_LAT + 1);
    localparam int LEAF_W   = 1 + OFS_W + IDX_W;
    localparam int PROD_W   = IDX_W + CFG_W;

    // Control state
    t_state           r_state, n_state;
    logic [LAT_W-1:0] r_lat, n_lat;
    logic [CNT_W-1:0] r_cnt;

    // Held request and configuration
    logic [1:0]       r_op;
    logic [KEY_W-1:0] r_req_key;
    logic [OFS_W-1:0] r_req_ofs;
    logic [CFG_W-1:0] r_hdr;
    logic [CFG_W-1:0] r_ebytes;

    // Result register
    logic                  r_rsp_valid;
    t_status               r_status, n_status;
    logic [OFS_W-1:0]      r_found, n_found;
    logic [SLOT_OUT_W-1:0] r_slot, n_slot;
    logic [IPOS_W-1:0]     r_ipos, n_ipos;

    logic      w_accept;
    logic      w_out_free;
    logic      w_apply_go;
    logic      w_full;
    t_cell_ctl w_ctl;

    // Chain taps
    logic [KEY_W-1:0]  w_key  [TABLE_DEPTH];
    logic [OFS_W-1:0]  w_ofs  [TABLE_DEPTH];
    logic              w_lt   [TABLE_DEPTH];
    logic              w_eq   [TABLE_DEPTH];
    logic [LEAF_W-1:0] w_leaf [TABLE_DEPTH];

    logic [LEAF_W-1:0] w_root;
    logic              w_root_found;
    logic [OFS_W-1:0]  w_root_ofs;
    logic [IDX_W-1:0]  w_root_idx;
    logic [PROD_W-1:0] w_prod;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_out_free  = !r_rsp_valid || o_rsp.ready;
    assign w_apply_go  = (r_state == S_APPLY) && w_out_free;
    assign w_full      = (r_cnt == CNT_W'(TABLE_DEPTH));

    // Broadcast: compare against the port key at accept, shift with the held pair.
    assign w_ctl.cmp = w_accept;
    assign w_ctl.ins = w_apply_go && (r_op == OP_INSERT) && !w_full;
    assign w_ctl.rem = w_apply_go && (r_op == OP_REMOVE) && w_root_found;
    assign w_ctl.key = (r_state == S_IDLE) ? i_req.key : r_req_key;
    assign w_ctl.ofs = r_req_ofs;

    // Row of cells, sorted ascending from slot 0.
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        logic             w_prev_lt;
        logic [KEY_W-1:0] w_prev_key;
        logic [OFS_W-1:0] w_prev_ofs;
        logic [KEY_W-1:0] w_next_key;
        logic [OFS_W-1:0] w_next_ofs;
        logic             w_bnd;

        if (g == 0) begin : g_first
            assign w_prev_lt  = 1'b1;
            assign w_prev_key = '0;
            assign w_prev_ofs = '0;
        end else begin : g_mid
            assign w_prev_lt  = w_lt[g-1];
            assign w_prev_key = w_key[g-1];
            assign w_prev_ofs = w_ofs[g-1];
        end

        if (g == TABLE_DEPTH - 1) begin : g_last
            assign w_next_key = w_key[g];
            assign w_next_ofs = w_ofs[g];
        end else begin : g_inner
            assign w_next_key = w_key[g+1];
            assign w_next_ofs = w_ofs[g+1];
        end

        skot_cell #(
            .INDEX (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_count    (r_cnt),
            .i_prev_lt  (w_prev_lt),
            .i_prev_key (w_prev_key),
            .i_prev_ofs (w_prev_ofs),
            .i_next_key (w_next_key),
            .i_next_ofs (w_next_ofs),
            .o_key      (w_key[g]),
            .o_ofs      (w_ofs[g]),
            .o_lt       (w_lt[g]),
            .o_eq       (w_eq[g])
        );

        // Lower-bound boundary: first cell whose key is not below the request.
        assign w_bnd     = !w_lt[g] && w_prev_lt;
        assign w_leaf[g] = w_bnd ? {w_eq[g], w_ofs[g], IDX_W'(g)} : '0;
    end

    skot_or_tree #(
        .N (TABLE_DEPTH),
        .W (LEAF_W)
    ) u_tree (
        .i_clk  (i_clk),
        .i_leaf (w_leaf),
        .o_root (w_root)
    );

    assign w_root_found = w_root[LEAF_W-1];
    assign w_root_ofs   = w_root[IDX_W +: OFS_W];
    assign w_root_idx   = w_root[IDX_W-1:0];
    assign w_prod       = PROD_W'(w_root_idx) * PROD_W'(r_ebytes);

    // Sequencer: accept, wait out the tree, apply.
    always_comb begin
        n_state = r_state;
        n_lat   = r_lat;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_REDUCE;
                    n_lat   = '0;
                end
            end
            S_REDUCE: begin
                if (r_lat == LAT_W'(TREE_LAT - 1)) begin
                    n_state = S_APPLY;
                end else begin
                    n_lat = r_lat + 1'b1;
                end
            end
            S_APPLY: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Result assembly from the tree root.
    always_comb begin
        n_status = ST_NOT_FOUND;
        n_found  = '0;
        n_slot   = '0;
        n_ipos   = '0;
        unique case (r_op)
            OP_INSERT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_status = ST_DONE;
                    n_slot   = SLOT_OUT_W'(w_root_idx);
                end
            end
            OP_REMOVE: begin
                if (w_root_found) begin
                    n_status = ST_DONE;
                    n_slot   = SLOT_OUT_W'(w_root_idx);
                end
            end
            OP_LOOKUP: begin
                if (w_root_found) begin
                    n_status = ST_DONE;
                    n_slot   = SLOT_OUT_W'(w_root_idx);
                    n_found  = w_root_ofs;
                    n_ipos   = IPOS_W'(w_prod) + IPOS_W'(r_hdr);
                end
            end
            default: begin
                // unused opcode: not found, no change
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lat       <= '0;
            r_cnt       <= '0;
            r_hdr       <= HEADER_BYTES_RST;
            r_ebytes    <= ENTRY_BYTES_RST;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_lat   <= n_lat;
            // Advance the fill count with the shift.
            if (w_ctl.ins) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_ctl.rem) begin
                r_cnt <= r_cnt - 1'b1;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_HEADER_BYTES: r_hdr    <= i_cfg_data;
                    CFG_ENTRY_BYTES:  r_ebytes <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (w_apply_go) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // Payload registers: hold the request and the result.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op      <= i_req.opcode;
            r_req_key <= i_req.key;
            r_req_ofs <= i_req.record_offset;
        end
        if (w_apply_go) begin
            r_status <= n_status;
            r_found  <= n_found;
            r_slot   <= n_slot;
            r_ipos   <= n_ipos;
        end
    end

    assign o_rsp.valid          = r_rsp_valid;
    assign o_rsp.status         = r_status;
    assign o_rsp.found_offset   = r_found;
    assign o_rsp.slot           = r_slot;
    assign o_rsp.index_position = r_ipos;

    // Fill count never runs past the table size.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(TABLE_DEPTH))
        else $error("fill count exceeds table depth");

    // A key match from the tree always lies inside the occupied slots.
    a_found_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPLY && w_root_found) |-> (CNT_W'(w_root_idx) < r_cnt))
        else $error("match reported beyond fill count");

    // An insert shift grows the table by exactly one entry.
    a_ins_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.ins |=> (r_cnt == CNT_W'($past(r_cnt) + 1'b1)))
        else $error("insert did not advance fill count");

    // A remove shift shrinks the table by exactly one entry.
    a_rem_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.rem |=> (r_cnt == CNT_W'($past(r_cnt) - 1'b1)))
        else $error("remove did not drop fill count");

endmodule
